### design/i128alu_pkg.sv
package i128alu_pkg;

    localparam int WORD_BITS_DEF = 128;
    localparam int HALF_BITS     = 64;
    localparam int FUNC_BITS     = 5;

    typedef enum logic [FUNC_BITS-1:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_MOD = 5'd4,
        OP_AND = 5'd5,
        OP_OR  = 5'd6,
        OP_XOR = 5'd7,
        OP_NOT = 5'd8,
        OP_SHL = 5'd9,
        OP_SHR = 5'd10,
        OP_ROL = 5'd11,
        OP_ROR = 5'd12,
        OP_GT  = 5'd13,
        OP_LT  = 5'd14,
        OP_EQ  = 5'd15,
        OP_GE  = 5'd16,
        OP_LE  = 5'd17
    } op_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [HALF_BITS-1:0] a_hi;
        logic [HALF_BITS-1:0] a_lo;
        logic [HALF_BITS-1:0] b_hi;
        logic [HALF_BITS-1:0] b_lo;
    } alu_req_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] res_hi;
        logic [HALF_BITS-1:0] res_lo;
        logic                 cmp_true;
        logic                 div_zero;
    } alu_rsp_t;

endpackage

### design/int128_signed_alu.sv
// channel | signals          | handshake
// --------+------------------+---------------------------------------------------
// request | start, busy, req | transaction taken at a rising edge, start high, busy low
// result  | done, rsp        | valid for the single cycle done is high
//
// add, sub, logic, compare and undefined codes run bit-serially, mul by shift-add, div by a
// restoring divide, mod by divide then multiply-back; a zero divisor goes straight to done;
// shifts and rotates first reduce the count mod WORD_BITS, then move one bit position at a time
// busy stays high through the done cycle, so the next transaction is taken only after done falls
// reset clears the sequencer; the receiver cannot stall, results are dropped if ignored
module int128_signed_alu
    import i128alu_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_req_t req,
    output logic     done,
    output alu_rsp_t rsp
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int SW = $clog2(W);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_PREP = 10'b00_0000_0010,
        S_SER  = 10'b00_0000_0100,
        S_MUL  = 10'b00_0000_1000,
        S_DIV  = 10'b00_0001_0000,
        S_FIX  = 10'b00_0010_0000,
        S_MUL2 = 10'b00_0100_0000,
        S_CNT  = 10'b00_1000_0000,
        S_ROT  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [FUNC_BITS-1:0] op_reg;
    logic [W-1:0] a_reg, b_reg, a0_reg, b0_reg;
    logic [W-1:0] acc_reg, q_reg, r_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] m_reg;
    logic carry_reg, eq_reg, lt_reg, neg_reg, big_reg;
    logic [W-1:0] res_reg;
    logic cmp_reg, dz_reg, done_reg;

    logic accept;
    assign accept = start && !busy;

    logic [2*HALF_BITS-1:0] a_full, b_full;
    assign a_full = {req.a_hi, req.a_lo};
    assign b_full = {req.b_hi, req.b_lo};

    // serial add/subtract bit
    logic ab, bb, sb, sc;
    assign ab = a_reg[0];
    assign bb = (op_reg == OP_SUB) ? ~b_reg[0] : b_reg[0];
    assign {sc, sb} = {1'b0, ab} + {1'b0, bb} + {1'b0, carry_reg};

    // divide step
    logic [W:0] rtrial;
    logic [W:0] rsh;
    assign rsh = {r_reg, q_reg[W-1]};
    assign rtrial = rsh - {1'b0, b_reg};

    // count reduced mod W one bit a cycle, msb first
    logic [SW:0] m_raw;
    assign m_raw = {m_reg, b_reg[W-1]};

    logic a_neg, b_neg, is_div, is_sh, slt;
    assign a_neg  = a0_reg[W-1];
    assign b_neg  = b0_reg[W-1];
    assign is_div = op_reg inside {OP_DIV, OP_MOD};
    assign is_sh  = op_reg inside {OP_SHL, OP_SHR, OP_ROL, OP_ROR};
    assign slt    = (a_neg != b_neg) ? a_neg : lt_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_PREP;
            S_PREP:
            begin
                case (op_reg) inside
                    OP_MUL: state_next = S_MUL;
                    OP_DIV, OP_MOD: state_next = (b0_reg == '0) ? S_DONE : S_DIV;
                    OP_SHL, OP_SHR, OP_ROL, OP_ROR: state_next = S_CNT;
                    default: state_next = S_SER;
                endcase
            end
            S_SER:  if (cnt_reg == CW'(W)) state_next = S_DONE;
            S_MUL:  if (cnt_reg == CW'(W)) state_next = S_DONE;
            S_DIV:  if (cnt_reg == CW'(W)) state_next = S_FIX;
            S_FIX:  state_next = (op_reg == OP_MOD) ? S_MUL2 : S_DONE;
            S_MUL2: if (cnt_reg == CW'(W)) state_next = S_DONE;
            S_CNT:  if (cnt_reg == CW'(W)) state_next = S_ROT;
            S_ROT:  if (m_reg == '0) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg <= req.func;
                    a0_reg <= a_full[W-1:0];
                    b0_reg <= b_full[W-1:0];
                end
            end
            S_PREP:
            begin
                cnt_reg   <= '0;
                carry_reg <= (op_reg == OP_SUB);
                acc_reg   <= is_sh ? a0_reg : '0;
                eq_reg    <= 1'b1;
                lt_reg    <= 1'b0;
                res_reg   <= '0;
                cmp_reg   <= 1'b0;
                dz_reg    <= is_div && (b0_reg == '0);
                a_reg     <= a0_reg;
                b_reg     <= (is_div && b_neg) ? -b0_reg : b0_reg;
                q_reg     <= !is_div ? '0 : (a_neg ? -a0_reg : a0_reg);
                r_reg     <= '0;
                neg_reg   <= a_neg ^ b_neg;
                m_reg     <= '0;
                big_reg   <= 1'b0;
            end
            S_SER:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != CW'(W))
                begin
                    a_reg     <= a_reg >> 1;
                    b_reg     <= b_reg >> 1;
                    carry_reg <= sc;
                    // unsigned lsb-first compare, sign fixed at the end
                    if (a_reg[0] != b_reg[0])
                    begin
                        eq_reg <= 1'b0;
                        lt_reg <= b_reg[0];
                    end
                    case (op_reg)
                        OP_ADD, OP_SUB: acc_reg <= {sb, acc_reg[W-1:1]};
                        OP_AND: acc_reg <= {a_reg[0] & b_reg[0], acc_reg[W-1:1]};
                        OP_OR:  acc_reg <= {a_reg[0] | b_reg[0], acc_reg[W-1:1]};
                        OP_XOR: acc_reg <= {a_reg[0] ^ b_reg[0], acc_reg[W-1:1]};
                        OP_NOT: acc_reg <= {~a_reg[0], acc_reg[W-1:1]};
                        default: acc_reg <= acc_reg;
                    endcase
                end
                else
                begin
                    res_reg <= (op_reg <= OP_NOT) ? acc_reg : '0;
                    case (op_reg)
                        OP_GT: cmp_reg <= !slt && !eq_reg;
                        OP_LT: cmp_reg <= slt;
                        OP_EQ: cmp_reg <= eq_reg;
                        OP_GE: cmp_reg <= !slt;
                        OP_LE: cmp_reg <= slt || eq_reg;
                        default: cmp_reg <= 1'b0;
                    endcase
                end
            end
            S_MUL, S_MUL2:
            begin
                // shift-add, lsb of multiplier first
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != CW'(W))
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
                else if (state_reg == S_MUL)
                begin
                    res_reg <= acc_reg;
                end
                else
                begin
                    res_reg <= a0_reg - acc_reg;
                end
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != CW'(W))
                begin
                    if (!rtrial[W])
                    begin
                        r_reg <= rtrial[W-1:0];
                        q_reg <= {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rsh[W-1:0];
                        q_reg <= {q_reg[W-2:0], 1'b0};
                    end
                end
            end
            S_FIX:
            begin
                cnt_reg <= '0;
                acc_reg <= '0;
                res_reg <= neg_reg ? -q_reg : q_reg;
                a_reg   <= b0_reg;
                b_reg   <= neg_reg ? -q_reg : q_reg;
            end
            S_CNT:
            begin
                // any reduction means the count is at least W
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != CW'(W))
                begin
                    b_reg <= b_reg << 1;
                    if (m_raw >= (SW+1)'(W))
                    begin
                        m_reg   <= SW'(m_raw - (SW+1)'(W));
                        big_reg <= 1'b1;
                    end
                    else
                    begin
                        m_reg <= m_raw[SW-1:0];
                    end
                end
            end
            S_ROT:
            begin
                // one bit position a cycle
                if (m_reg != '0)
                begin
                    m_reg <= m_reg - 1'b1;
                    case (op_reg)
                        OP_SHL: acc_reg <= {acc_reg[W-2:0], 1'b0};
                        OP_SHR: acc_reg <= {1'b0, acc_reg[W-1:1]};
                        OP_ROL: acc_reg <= {acc_reg[W-2:0], acc_reg[W-1]};
                        OP_ROR: acc_reg <= {acc_reg[0], acc_reg[W-1:1]};
                        default: acc_reg <= acc_reg;
                    endcase
                end
                else
                begin
                    res_reg <= (big_reg && (op_reg inside {OP_SHL, OP_SHR})) ? '0 : acc_reg;
                end
            end
            default: cnt_reg <= cnt_reg;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    always_comb
    begin
        logic [2*HALF_BITS-1:0] wide;
        wide = '0;
        wide[W-1:0] = res_reg;
        rsp.res_hi   = wide[2*HALF_BITS-1:HALF_BITS];
        rsp.res_lo   = wide[HALF_BITS-1:0];
        rsp.cmp_true = cmp_reg;
        rsp.div_zero = dz_reg;
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DONE))
        else $error("result strobe without finish");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == S_PREP)
        else $error("transaction not taken");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.cmp_true && rsp.div_zero))
        else $error("both flags set");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import i128alu_pkg::*;

    localparam int W = WORD_BITS_DEF;
    localparam int N_ITEMS = 650;
    localparam int PAUSE_AT = N_ITEMS / 2;
    localparam longint CYCLE_LIMIT = 1200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    alu_req_t req;
    logic     done;
    alu_rsp_t rsp;

    alu_req_t pend_q[$];
    alu_rsp_t exp_q[$];
    alu_rsp_t exp_rsp;
    logic     taken;
    logic     go;
    logic     paused = 1'b0;
    int       idle_pct;
    int       sent_cnt = 0;
    int       res_cnt = 0;
    int       err_cnt = 0;
    longint   cycle_cnt = 0;

    int128_signed_alu u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    function automatic logic [W-1:0] pick_word();
        logic [W-1:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        v = {$urandom, $urandom, $urandom, $urandom};
        case (sel)
            0: v = '0;
            1: v = {W{1'b1}};
            2: v = {1'b1, {(W-1){1'b0}}};
            3: v = W'($urandom_range(0, 300));
            4: v = -W'($urandom_range(1, 300));
            5: v = {1'b0, {(W-1){1'b1}}};
            6: v = v >> $urandom_range(0, W - 1);
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic alu_req_t make_req(int idx);
        alu_req_t r;
        logic [W-1:0] a, b;
        int f;
        f = (idx < 60) ? (idx % 20) : $urandom_range(0, 19);
        if (f >= 18)
        begin
            f = $urandom_range(18, 31);
        end
        a = pick_word();
        b = pick_word();
        r.func = f[FUNC_BITS-1:0];
        r.a_hi = a[W-1:HALF_BITS];
        r.a_lo = a[HALF_BITS-1:0];
        r.b_hi = b[W-1:HALF_BITS];
        r.b_lo = b[HALF_BITS-1:0];
        return r;
    endfunction

    function automatic alu_rsp_t predict(alu_req_t r);
        alu_rsp_t p;
        logic [W-1:0] a, b, res, ua, ub, q;
        logic neg, big;
        int unsigned rot;
        a = {r.a_hi, r.a_lo};
        b = {r.b_hi, r.b_lo};
        p = '0;
        res = '0;
        big = (b >= W'(W));
        rot = int'(b % W);
        ua = a[W-1] ? -a : a;
        ub = b[W-1] ? -b : b;
        neg = a[W-1] ^ b[W-1];
        q = '0;
        if (b != '0)
        begin
            q = ua / ub;
            if (neg)
            begin
                q = -q;
            end
        end
        case (r.func)
            OP_ADD: res = a + b;
            OP_SUB: res = a - b;
            OP_MUL: res = a * b;
            OP_DIV:
            begin
                if (b == '0) p.div_zero = 1'b1;
                else res = q;
            end
            OP_MOD:
            begin
                if (b == '0) p.div_zero = 1'b1;
                else res = a - b * q;
            end
            OP_AND: res = a & b;
            OP_OR:  res = a | b;
            OP_XOR: res = a ^ b;
            OP_NOT: res = ~a;
            OP_SHL: res = big ? '0 : (a << b);
            OP_SHR: res = big ? '0 : (a >> b);
            OP_ROL: res = (rot == 0) ? a : ((a << rot) | (a >> (W - rot)));
            OP_ROR: res = (rot == 0) ? a : ((a >> rot) | (a << (W - rot)));
            OP_GT:  p.cmp_true = ($signed(a) > $signed(b));
            OP_LT:  p.cmp_true = ($signed(a) < $signed(b));
            OP_EQ:  p.cmp_true = (a == b);
            OP_GE:  p.cmp_true = ($signed(a) >= $signed(b));
            OP_LE:  p.cmp_true = ($signed(a) <= $signed(b));
            default: res = '0;
        endcase
        p.res_hi = res[W-1:HALF_BITS];
        p.res_lo = res[HALF_BITS-1:0];
        return p;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < N_ITEMS; i++)
        begin
            pend_q.push_back(make_req(i));
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: holds a transaction until taken, then idles or sends the next
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else if (!start || taken)
        begin
            if (sent_cnt < N_ITEMS / 3)
                idle_pct = 36;
            else if (sent_cnt < 2 * N_ITEMS / 3)
                idle_pct = 85;
            else
                idle_pct = 0;
            go = (pend_q.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
            // wait for every outstanding result once mid-run
            if (sent_cnt == PAUSE_AT && !paused)
            begin
                go = 1'b0;
                if (exp_q.size() == 0)
                begin
                    paused = 1'b1;
                end
            end
            if (go)
            begin
                req   <= pend_q.pop_front();
                start <= 1'b1;
                sent_cnt++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on acceptance, checks on the strobe
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: no finish within %0d cycles, %0d results seen", CYCLE_LIMIT, res_cnt);
            $display("tb: FAIL");
            $finish;
        end
        if (!rst_n)
        begin
            taken <= 1'b0;
        end
        else
        begin
            taken <= start && !busy;
            if (start && !busy)
            begin
                exp_q.push_back(predict(req));
            end
            if (done)
            begin
                if (exp_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                end
                else
                begin
                    exp_rsp = exp_q.pop_front();
                    if (rsp !== exp_rsp)
                    begin
                        err_cnt++;
                        $display("%0t: mismatch, expected %h, actual %h", $time, exp_rsp, rsp);
                    end
                    res_cnt++;
                    if (res_cnt == N_ITEMS)
                    begin
                        if (pend_q.size() != 0)
                        begin
                            err_cnt++;
                        end
                        $display("tb: %0d transactions checked over every operation code,", res_cnt);
                        $display("tb: corner operands, sender idle 36%%, 85%% then 0%%, one drain");
                        if (err_cnt == 0)
                            $display("tb: PASS");
                        else
                            $display("tb: FAIL");
                        $finish;
                    end
                end
            end
        end
    end

endmodule
